### hdl/dql_pkg.sv
// Shared types, constants and fixed-point helpers for the double Q-learning engine.
package dql_pkg;

   localparam int Q_W        = 32;
   localparam int TD_W       = 34;
   localparam int PROD_W     = 51;
   localparam int SAT_W      = 36;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0]  CSR_LEARN_RATE   = 8'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_DISCOUNT     = 8'd1;
   localparam logic [CSR_DATA_W-1:0] LEARN_RATE_RESET = 16'd6554;
   localparam logic [CSR_DATA_W-1:0] DISCOUNT_RESET   = 16'd58982;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN1,
      ST_READ,
      ST_LOAD,
      ST_MUL1,
      ST_TD,
      ST_MUL2,
      ST_STEP,
      ST_SUM,
      ST_SCAN2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic first;
      logic valid;
   } scan_ctl_type;

   typedef struct packed {
      logic signed [Q_W-1:0] value;
      logic                  clip;
   } sat_type;

   // Rounds a Q.32 value to Q.16: add one half, then floor.
   function automatic logic signed [TD_W-1:0] rnd16(input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] t;
      t = x + $signed(PROD_W'(32768));
      return t[TD_W+15:16];
   endfunction

   // Clips a wide signed value to the 32-bit range.
   function automatic sat_type sat32(input logic signed [SAT_W-1:0] x);
      sat_type r;
      if (x[SAT_W-1:Q_W-1] != {(SAT_W-Q_W+1){1'b0}} &&
          x[SAT_W-1:Q_W-1] != {(SAT_W-Q_W+1){1'b1}}) begin
         r.clip  = 1'b1;
         r.value = x[SAT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r.clip  = 1'b0;
         r.value = x[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

### hdl/dql_ram.sv
// Single-port-write, single-port-read value table with registered read data.
module dql_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [31:0]   wdata,
   input  logic [AW-1:0] raddr,
   output logic [31:0]   rdata
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/dql_argmax.sv
// Running argmax over one table row, fed one entry per cycle; lowest index wins ties.
module dql_argmax #(
   parameter int AW = 3
) (
   input  logic                  clock,
   input  dql_pkg::scan_ctl_type ctl,
   input  logic [AW-1:0]         idx,
   input  logic signed [31:0]    value,
   output logic [AW-1:0]         best
);
   import dql_pkg::*;

   logic signed [31:0] best_val_ff, best_val_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;

   always_comb begin
      best_val_in = best_val_ff;
      best_idx_in = best_idx_ff;
      if (ctl.valid && (ctl.first || value > best_val_ff)) begin
         best_val_in = value;
         best_idx_in = idx;
      end
   end

   always_ff @(posedge clock) begin
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
   end

   assign best = best_idx_ff;

endmodule

### hdl/dql_mul.sv
// Shared registered multiplier: unsigned Q0.16 factor times a signed operand.
module dql_mul (
   input  logic                                 clock,
   input  logic [15:0]                          op_a,
   input  logic signed [dql_pkg::TD_W-1:0]      op_b,
   output logic signed [dql_pkg::PROD_W-1:0]    prod
);
   import dql_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = $signed({1'b0, op_a}) * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### hdl/double_q_learning_update.sv
// Top level of the tabular double Q-learning engine: sequencer, tables and datapath.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_tvalid / req_tready | tdata: transition, tuser: coin
//  rsp     | out       | rsp_tvalid / rsp_tready | tdata: new values, tuser: saturated
//  csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// The time from accepting an item to the next ready is set by two walks over a
// table row through the single read port of each table plus seven steps around
// the shared multiplier.
// After reset a clearing pass writes zero to all STATE_COUNT*ACTION_COUNT entries,
// one per cycle; no item is accepted meanwhile.
// A finished result waits in the output register while the next item is worked on.
module double_q_learning_update #(
   parameter int STATE_COUNT  = 64,
   parameter int ACTION_COUNT = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // prev_state[5:0], taken_action[8:6], reward[40:9], arrived_state[46:41]
   input  logic [47:0]                        req_tdata,
   // coin[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // new_entry[31:0], new_sum[63:32], greedy_action[66:64]
   output logic [71:0]                        rsp_tdata,
   // saturated[0]
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dql_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dql_pkg::CSR_DATA_W-1:0]     csr_data
);
   import dql_pkg::*;

   localparam int ENTRIES = STATE_COUNT * ACTION_COUNT;
   localparam int IW      = $clog2(ENTRIES);
   localparam int AW      = $clog2(ACTION_COUNT);
   localparam int CW      = $clog2(ACTION_COUNT + 1);

   function automatic logic [5:0] state_mod(input logic [5:0] s);
      logic [18:0] r;
      r = 19'(s);
      for (int k = 5; k >= 0; k--) begin
         if (r >= (19'(STATE_COUNT) << k)) begin
            r = r - (19'(STATE_COUNT) << k);
         end
      end
      return r[5:0];
   endfunction

   function automatic logic [2:0] action_mod(input logic [2:0] a);
      logic [8:0] r;
      r = 9'(a);
      for (int k = 2; k >= 0; k--) begin
         if (r >= (9'(ACTION_COUNT) << k)) begin
            r = r - (9'(ACTION_COUNT) << k);
         end
      end
      return r[2:0];
   endfunction

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [15:0]   learn_ff, learn_in;
   logic [15:0]   disc_ff, disc_in;

   logic [5:0]         prev_ff, prev_in;
   logic [2:0]         act_ff, act_in;
   logic [5:0]         arr_ff, arr_in;
   logic               coin_ff, coin_in;
   logic signed [31:0] reward_ff, reward_in;
   logic signed [31:0] qself_ff, qself_in;
   logic signed [31:0] qother_ff, qother_in;
   logic signed [31:0] oth_ff, oth_in;
   logic signed [TD_W-1:0] td16_ff, td16_in;
   logic signed [31:0] entry_ff, entry_in;
   logic signed [31:0] sum_ff, sum_in;
   logic               clip_ff, clip_in;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic signed [31:0] rsp_entry_ff, rsp_entry_in;
   logic signed [31:0] rsp_sum_ff, rsp_sum_in;
   logic [2:0]         rsp_act_ff, rsp_act_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic [IW-1:0] row_base, idx, scan_addr, waddr;
   logic [IW-1:0] self_raddr, other_raddr, a_raddr, b_raddr, s_raddr;
   logic          a_we, b_we, s_we;
   logic [31:0]   ab_wdata, s_wdata;
   logic signed [31:0] a_rdata, b_rdata, s_rdata, self_rdata, other_rdata;

   scan_ctl_type       scan_ctl;
   logic [AW-1:0]      arg_idx, arg_best;
   logic signed [31:0] arg_value;

   logic [15:0]              mul_a;
   logic signed [TD_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod;

   logic signed [PROD_W-1:0] rew_w, qs_w, td32;
   logic signed [TD_W-1:0]   step;
   logic signed [SAT_W-1:0]  ent_w, sum_w;
   sat_type                  ent_res, sum_res;
   logic                     accept, rsp_free, scan_end;

   assign accept    = req_tvalid && req_tready;
   assign rsp_free  = !rsp_tvalid_ff || rsp_tready;
   assign scan_end  = (cnt_ff == CW'(ACTION_COUNT));
   assign row_base  = IW'(IW'(arr_ff) * IW'(ACTION_COUNT));
   assign idx       = IW'(IW'(prev_ff) * IW'(ACTION_COUNT) + IW'(act_ff));
   assign scan_addr = row_base + IW'(cnt_ff);

   assign self_rdata  = coin_ff ? a_rdata : b_rdata;
   assign other_rdata = coin_ff ? b_rdata : a_rdata;
   assign a_raddr     = coin_ff ? self_raddr : other_raddr;
   assign b_raddr     = coin_ff ? other_raddr : self_raddr;

   // Fixed-point datapath around the shared multiplier.
   assign rew_w   = {{(PROD_W-48){reward_ff[31]}}, reward_ff, 16'h0000};
   assign qs_w    = {{(PROD_W-48){qself_ff[31]}}, qself_ff, 16'h0000};
   assign td32    = rew_w + prod - qs_w;
   assign step    = rnd16(prod);
   assign ent_w   = SAT_W'(qself_ff) + SAT_W'(step);
   assign ent_res = sat32(ent_w);
   assign sum_w   = SAT_W'(entry_ff) + SAT_W'(oth_ff);
   assign sum_res = sat32(sum_w);

   dql_ram #(.DEPTH(ENTRIES), .AW(IW)) u_table_a (
      .clock (clock), .we (a_we), .waddr (waddr), .wdata (ab_wdata),
      .raddr (a_raddr), .rdata (a_rdata)
   );

   dql_ram #(.DEPTH(ENTRIES), .AW(IW)) u_table_b (
      .clock (clock), .we (b_we), .waddr (waddr), .wdata (ab_wdata),
      .raddr (b_raddr), .rdata (b_rdata)
   );

   dql_ram #(.DEPTH(ENTRIES), .AW(IW)) u_table_sum (
      .clock (clock), .we (s_we), .waddr (waddr), .wdata (s_wdata),
      .raddr (s_raddr), .rdata (s_rdata)
   );

   dql_argmax #(.AW(AW)) u_argmax (
      .clock (clock), .ctl (scan_ctl), .idx (arg_idx), .value (arg_value),
      .best (arg_best)
   );

   dql_mul u_mul (
      .clock (clock), .op_a (mul_a), .op_b (mul_b), .prod (prod)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IW'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN1;
            end
         end
         ST_SCAN1: begin
            if (scan_end) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_TD;
         ST_TD:    state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_STEP;
         ST_STEP:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_SCAN2;
         ST_SCAN2: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: table ports, walk control and multiplier operands.
   always_comb begin
      req_tready     = 1'b0;
      a_we           = 1'b0;
      b_we           = 1'b0;
      s_we           = 1'b0;
      waddr          = idx;
      ab_wdata       = entry_ff;
      s_wdata        = sum_res.value;
      self_raddr     = scan_addr;
      other_raddr    = scan_addr;
      s_raddr        = scan_addr;
      scan_ctl.valid = 1'b0;
      scan_ctl.first = 1'b0;
      arg_value      = self_rdata;
      mul_a          = disc_ff;
      mul_b          = TD_W'(qother_ff);
      case (state_ff)
         ST_CLEAR: begin
            a_we     = 1'b1;
            b_we     = 1'b1;
            s_we     = 1'b1;
            waddr    = clr_ff;
            ab_wdata = 32'h0;
            s_wdata  = 32'h0;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SCAN1: begin
            scan_ctl.valid = (cnt_ff != '0);
            scan_ctl.first = (cnt_ff == CW'(1));
         end
         ST_READ: begin
            self_raddr  = idx;
            other_raddr = row_base + IW'(arg_best);
         end
         ST_LOAD: begin
            other_raddr = idx;
         end
         ST_MUL2: begin
            mul_a = learn_ff;
            mul_b = td16_ff;
         end
         ST_SUM: begin
            a_we = coin_ff;
            b_we = !coin_ff;
            s_we = 1'b1;
         end
         ST_SCAN2: begin
            scan_ctl.valid = (cnt_ff != '0);
            scan_ctl.first = (cnt_ff == CW'(1));
            arg_value      = s_rdata;
         end
         default: begin
         end
      endcase
   end

   // Data arriving at walk step n belongs to the entry issued in the previous cycle, as table reads are registered.
   assign arg_idx = AW'(cnt_ff - CW'(1));

   // Counters, configuration and datapath registers.
   always_comb begin
      clr_in  = clr_ff;
      cnt_in  = '0;
      learn_in = learn_ff;
      disc_in  = disc_ff;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + IW'(1);
      end
      if ((state_ff == ST_SCAN1 || state_ff == ST_SCAN2) && !scan_end) begin
         cnt_in = cnt_ff + CW'(1);
      end
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_LEARN_RATE) begin
            learn_in = csr_data;
         end else if (csr_index == CSR_DISCOUNT) begin
            disc_in = csr_data;
         end
      end
   end

   always_comb begin
      prev_in       = prev_ff;
      act_in        = act_ff;
      arr_in        = arr_ff;
      coin_in       = coin_ff;
      reward_in     = reward_ff;
      qself_in      = qself_ff;
      qother_in     = qother_ff;
      oth_in        = oth_ff;
      td16_in       = td16_ff;
      entry_in      = entry_ff;
      sum_in        = sum_ff;
      clip_in       = clip_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_sat_in    = rsp_sat_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               prev_in   = state_mod(req_tdata[5:0]);
               act_in    = action_mod(req_tdata[8:6]);
               reward_in = req_tdata[40:9];
               arr_in    = state_mod(req_tdata[46:41]);
               coin_in   = req_tuser;
            end
         end
         ST_LOAD: begin
            qself_in  = self_rdata;
            qother_in = other_rdata;
         end
         ST_MUL1: begin
            oth_in = other_rdata;
         end
         ST_TD: begin
            td16_in = rnd16(td32);
         end
         ST_STEP: begin
            entry_in = ent_res.value;
            clip_in  = ent_res.clip;
         end
         ST_SUM: begin
            sum_in  = sum_res.value;
            clip_in = clip_ff | sum_res.clip;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_entry_in  = entry_ff;
               rsp_sum_in    = sum_ff;
               rsp_act_in    = 3'(arg_best);
               rsp_sat_in    = clip_ff;
               rsp_tvalid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         clr_ff        <= '0;
         learn_ff      <= LEARN_RATE_RESET;
         disc_ff       <= DISCOUNT_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         clr_ff        <= clr_in;
         learn_ff      <= learn_in;
         disc_ff       <= disc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff      <= prev_in;
      act_ff       <= act_in;
      arr_ff       <= arr_in;
      coin_ff      <= coin_in;
      reward_ff    <= reward_in;
      qself_ff     <= qself_in;
      qother_ff    <= qother_in;
      oth_ff       <= oth_in;
      td16_ff      <= td16_in;
      entry_ff     <= entry_in;
      sum_ff       <= sum_in;
      clip_ff      <= clip_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_act_ff   <= rsp_act_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b0, rsp_act_ff, rsp_sum_ff, rsp_entry_ff};
   assign rsp_tuser  = rsp_sat_ff;

   // An accepted item keeps the block busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset) accept |=> !req_tready)
      else $error("item accepted on two consecutive cycles");

   // Outside the clearing pass an update touches exactly one of the two tables.
   assert property (@(posedge clock) disable iff (reset)
      (a_we && b_we) |-> (state_ff == ST_CLEAR))
      else $error("both value tables written outside the clearing pass");

   // The row walk never runs past the last action.
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CW'(ACTION_COUNT))
      else $error("row walk counter out of range");

   // A new result appears only after the final row walk has finished.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the completion step");

   // Nothing moves on the streams while the tables are being cleared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!req_tready && !rsp_tvalid_ff))
      else $error("stream activity during the clearing pass");

endmodule
